// File: sv/tpet_pkg.sv
// Package: event codes, register indexes and result types for the tablet pointer tracker.
`default_nettype none
package tpet_pkg;

  localparam int POS_W    = 15;
  localparam int SCR_W    = 13;
  localparam int PROD_W   = POS_W + SCR_W;
  localparam int TYPE_W   = 16;
  localparam int CODE_W   = 16;
  localparam int VALUE_W  = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic [POS_W-1:0]  POS_MAX    = 15'h7FFF;
  localparam logic [POS_W-1:0]  POS_CENTRE = 15'd16383;
  localparam logic [TYPE_W-1:0] EVT_KEY    = 16'h0001;
  localparam logic [TYPE_W-1:0] EVT_ABS    = 16'h0003;
  localparam logic [CODE_W-1:0] CODE_X     = 16'h0000;
  localparam logic [CODE_W-1:0] CODE_Y     = 16'h0001;
  localparam logic [CODE_W-1:0] CODE_LEFT  = 16'h0110;
  localparam logic [CODE_W-1:0] CODE_RIGHT = 16'h0111;

  localparam logic [SCR_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [SCR_W-1:0] HEIGHT_RESET = 13'd768;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic KIND_BUTTON = 1'b0;
  localparam logic KIND_MOTION = 1'b1;
  localparam logic IDX_LEFT    = 1'b0;
  localparam logic IDX_RIGHT   = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             idx;
    logic             pressed;
    logic             last;
  } raw_res_t;

  // p / 32767 for p < 2^28: q0 = p >> 15 leaves remainder (p & 0x7FFF) + q0,
  // which stays below twice the divisor, so one correction step suffices.
  function automatic logic [SCR_W-1:0] div_pos_max(input logic [PROD_W-1:0] p);
    logic [SCR_W-1:0] q0;
    logic [POS_W:0]   r;
    q0 = p[PROD_W-1:POS_W];
    r  = {1'b0, p[POS_W-1:0]} + {{(POS_W+1-SCR_W){1'b0}}, q0};
    return q0 + {{(SCR_W-1){1'b0}}, (r >= {1'b0, POS_MAX})};
  endfunction

endpackage
`default_nettype wire

// File: sv/tablet_pointer_event_tracker.sv
// Tablet pointer tracker: position state, event decode, scaling pipeline and output register.
// A result passes from stage A through stages B and C to the output register.
// Throughput: one event per cycle while the output is not stalled; an event giving both a button
// and a motion result holds the decode stage for a second phase, set by the single result path into the scaler.
// Scaling is one 13x15 multiply per axis, then a constant divide by shift, add and compare.
// Reset (synchronous, active high): position to centre 16383, moved mark clear,
// screen size 1024 x 768, all stages empty.
`default_nettype none
module tablet_pointer_event_tracker
  import tpet_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire [TYPE_W-1:0]       event_type,
  input  wire [CODE_W-1:0]       event_code,
  input  wire [VALUE_W-1:0]      event_value,
  input  wire                    batch_end,
  output logic                   out_valid,
  input  wire                    out_stall,
  output logic                   result_kind,
  output logic [SCR_W-1:0]       screen_x,
  output logic [SCR_W-1:0]       screen_y,
  output logic                   button_index,
  output logic                   button_pressed,
  output logic                   last_result,
  input  wire                    write_enable,
  input  wire [CFG_IDX_W-1:0]    write_index,
  input  wire [SCR_W-1:0]        write_data
);

  // configuration
  logic [SCR_W-1:0] screen_width;
  logic [SCR_W-1:0] screen_height;

  // tracked state
  logic [POS_W-1:0] position_x;
  logic [POS_W-1:0] position_y;
  logic             moved_flag;

  // stage A: input register
  logic              a_v;
  logic              a_phase;
  logic [TYPE_W-1:0] a_type;
  logic [CODE_W-1:0] a_code;
  logic [VALUE_W-1:0] a_value;
  logic              a_batch_end;

  // stage B: raw result, stage C: products, stage O: output
  logic             b_v;
  raw_res_t         b_res;
  logic             c_v;
  logic [PROD_W-1:0] c_prod_x;
  logic [PROD_W-1:0] c_prod_y;
  logic             c_kind;
  logic             c_idx;
  logic             c_pressed;
  logic             c_last;
  logic             o_v;

  // decode
  logic             is_abs;
  logic             is_btn;
  logic             is_axis;
  logic [POS_W-1:0] pos_sat;
  logic [POS_W-1:0] pos_x_next;
  logic [POS_W-1:0] pos_y_next;
  logic             moved_next;
  logic             emit_motion;
  logic             want_emit;
  logic             final_emit;
  raw_res_t         raw_now;

  logic o_ready, c_ready, b_ready;
  logic a_push, a_retire, a_ready, in_accept;

  always_comb begin
    is_abs  = (a_type == EVT_ABS);
    is_btn  = (a_type == EVT_KEY) && ((a_code == CODE_LEFT) || (a_code == CODE_RIGHT));
    is_axis = is_abs && ((a_code == CODE_X) || (a_code == CODE_Y));
    pos_sat = (a_value > {{(VALUE_W-POS_W){1'b0}}, POS_MAX}) ? POS_MAX : a_value[POS_W-1:0];
    pos_x_next = (is_abs && (a_code == CODE_X)) ? pos_sat : position_x;
    pos_y_next = (is_abs && (a_code == CODE_Y)) ? pos_sat : position_y;
    moved_next  = moved_flag | is_axis;
    emit_motion = a_batch_end && moved_next;
    want_emit   = (is_btn && !a_phase) || emit_motion;
    final_emit  = !(is_btn && !a_phase && emit_motion);

    raw_now.pos_x = pos_x_next;
    raw_now.pos_y = pos_y_next;
    if (is_btn && !a_phase) begin
      raw_now.kind    = KIND_BUTTON;
      raw_now.idx     = (a_code == CODE_LEFT) ? IDX_LEFT : IDX_RIGHT;
      raw_now.pressed = (a_value != '0);
      raw_now.last    = !emit_motion;
    end else begin
      raw_now.kind    = KIND_MOTION;
      raw_now.idx     = 1'b0;
      raw_now.pressed = 1'b0;
      raw_now.last    = 1'b1;
    end
  end

  assign o_ready   = !o_v || !out_stall;
  assign c_ready   = !c_v || o_ready;
  assign b_ready   = !b_v || c_ready;
  assign a_push    = a_v && want_emit && b_ready;
  assign a_retire  = a_v && (!want_emit || (b_ready && final_emit));
  assign a_ready   = !a_v || a_retire;
  assign in_stall  = !a_ready;
  assign in_accept = in_valid && a_ready;
  assign out_valid = o_v;

  // config and tracked state
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      position_x    <= POS_CENTRE;
      position_y    <= POS_CENTRE;
      moved_flag    <= 1'b0;
    end else begin
      if (write_enable) begin
        case (write_index)
          REG_SCREEN_WIDTH:  screen_width  <= write_data;
          REG_SCREEN_HEIGHT: screen_height <= write_data;
          default: ;
        endcase
      end
      if (a_retire) begin
        position_x <= pos_x_next;
        position_y <= pos_y_next;
        moved_flag <= emit_motion ? 1'b0 : moved_next;
      end
    end
  end

  // stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v     <= 1'b0;
      a_phase <= 1'b0;
    end else begin
      if (a_ready) a_v <= in_valid;
      if (a_retire) begin
        a_phase <= 1'b0;
      end else if (a_push) begin
        a_phase <= 1'b1;
      end
    end
    if (in_accept) begin
      a_type      <= event_type;
      a_code      <= event_code;
      a_value     <= event_value;
      a_batch_end <= batch_end;
    end
  end

  // stage B
  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (b_ready) begin
      b_v <= a_push;
    end
    if (b_ready && a_push) b_res <= raw_now;
  end

  // stage C: scale multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (c_ready) begin
      c_v <= b_v;
    end
    if (c_ready && b_v) begin
      c_prod_x  <= PROD_W'(screen_width) * PROD_W'(b_res.pos_x);
      c_prod_y  <= PROD_W'(screen_height) * PROD_W'(b_res.pos_y);
      c_kind    <= b_res.kind;
      c_idx     <= b_res.idx;
      c_pressed <= b_res.pressed;
      c_last    <= b_res.last;
    end
  end

  // output register: divide by full scale
  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (o_ready) begin
      o_v <= c_v;
    end
    if (o_ready && c_v) begin
      result_kind    <= c_kind;
      screen_x       <= div_pos_max(c_prod_x);
      screen_y       <= div_pos_max(c_prod_y);
      button_index   <= c_idx;
      button_pressed <= c_pressed;
      last_result    <= c_last;
    end
  end

`ifndef SYNTH
  a_phase_needs_item: assert property (@(posedge clk) disable iff (rst)
    a_phase |-> a_v)
    else $error("second result phase without an event held");

  two_result_split: assert property (@(posedge clk) disable iff (rst)
    (a_push && !final_emit) |=> (a_v && a_phase))
    else $error("button result not followed by motion phase");

  batch_clears_moved: assert property (@(posedge clk) disable iff (rst)
    (a_retire && a_batch_end) |=> !moved_flag)
    else $error("moved mark survived end of batch");

  motion_is_last: assert property (@(posedge clk) disable iff (rst)
    (o_v && (result_kind == KIND_MOTION)) |-> last_result)
    else $error("motion result not marked last");
`endif

endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for the tablet pointer event tracker: directed table, random batches, scoreboard.
module tb;
  import tpet_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FROM_PREDICTOR  = -1;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int PHASES          = 6;
  localparam int PRESSURE_PHASE  = 2;
  localparam int HOLD_CYCLES     = 80;
  localparam int SETTLE_CYCLES   = 6;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int MAX_REPORTS     = 100;

  typedef struct packed {
    logic             kind;
    logic [SCR_W-1:0] x;
    logic [SCR_W-1:0] y;
    logic             idx;
    logic             pressed;
    logic             last;
  } screen_result_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [SCR_W-1:0]   w;
    logic [SCR_W-1:0]   h;
    logic [TYPE_W-1:0]  ty;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] val;
    logic               last;
    int                 n_typed;
    screen_result_t     r0;
    screen_result_t     r1;
  } event_row_t;

  localparam screen_result_t NO_RESULT = '0;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TYPE_W-1:0]    event_type = '0;
  logic [CODE_W-1:0]    event_code = '0;
  logic [VALUE_W-1:0]   event_value = '0;
  logic                 batch_end = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 result_kind;
  logic [SCR_W-1:0]     screen_x;
  logic [SCR_W-1:0]     screen_y;
  logic                 button_index;
  logic                 button_pressed;
  logic                 last_result;
  logic                 write_enable = 1'b0;
  logic [CFG_IDX_W-1:0] write_index = '0;
  logic [SCR_W-1:0]     write_data = '0;

  tablet_pointer_event_tracker uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .event_type(event_type), .event_code(event_code),
    .event_value(event_value), .batch_end(batch_end),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .screen_x(screen_x), .screen_y(screen_y),
    .button_index(button_index), .button_pressed(button_pressed),
    .last_result(last_result),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data)
  );

  always #1 clk = ~clk;

  // predictor state and configuration
  logic [SCR_W-1:0] screen_w = WIDTH_RESET;
  logic [SCR_W-1:0] screen_h = HEIGHT_RESET;
  logic [POS_W-1:0] ptr_x = POS_CENTRE;
  logic [POS_W-1:0] ptr_y = POS_CENTRE;
  bit               moved = 1'b0;

  screen_result_t awaited_results[$];
  event_row_t     directed_rows[$];
  int             mismatches = 0;
  int             cycles = 0;
  int             stall_pct = 30;
  int             gap_pct = 30;
  bit             hold_order = 1'b0;
  bit             valid_up = 1'b0;

  int phase_w[PHASES]     = '{8191, 1, 8191, 1, -1, 1024};
  int phase_h[PHASES]     = '{8191, 1, 1, 8191, -1, 768};
  int phase_stall[PHASES] = '{30, 0, 20, 50, 25, 10};
  int phase_gap[PHASES]   = '{30, 0, 10, 50, 25, 40};

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [SCR_W-1:0] scale_to_screen(input logic [SCR_W-1:0] size,
                                                       input logic [POS_W-1:0] pos);
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] quot;
    product = PROD_W'(size) * PROD_W'(pos);
    quot    = product / PROD_W'(POS_MAX);
    return quot[SCR_W-1:0];
  endfunction

  // Updates the tracked position and, when keep is set, queues the results this event causes.
  task automatic apply_event(input logic [TYPE_W-1:0] ty, input logic [CODE_W-1:0] code,
                             input logic [VALUE_W-1:0] val, input logic last, input bit keep);
    screen_result_t   found[$];
    screen_result_t   r;
    logic [POS_W-1:0] pos;
    pos = (val > VALUE_W'(POS_MAX)) ? POS_MAX : val[POS_W-1:0];
    if (ty == EVT_ABS) begin
      if (code == CODE_X) begin
        ptr_x = pos;
        moved = 1'b1;
      end else if (code == CODE_Y) begin
        ptr_y = pos;
        moved = 1'b1;
      end
    end else if (ty == EVT_KEY && (code == CODE_LEFT || code == CODE_RIGHT)) begin
      r.kind    = KIND_BUTTON;
      r.x       = scale_to_screen(screen_w, ptr_x);
      r.y       = scale_to_screen(screen_h, ptr_y);
      r.idx     = (code == CODE_RIGHT) ? IDX_RIGHT : IDX_LEFT;
      r.pressed = (val != '0);
      r.last    = 1'b0;
      found.push_back(r);
    end
    // any event can close a batch, known or not
    if (last && moved) begin
      r.kind    = KIND_MOTION;
      r.x       = scale_to_screen(screen_w, ptr_x);
      r.y       = scale_to_screen(screen_h, ptr_y);
      r.idx     = 1'b0;
      r.pressed = 1'b0;
      r.last    = 1'b0;
      found.push_back(r);
      moved = 1'b0;
    end
    if (found.size() > 0) found[found.size()-1].last = 1'b1;
    if (keep) foreach (found[i]) awaited_results.push_back(found[i]);
  endtask

  task automatic send_event(input logic [TYPE_W-1:0] ty, input logic [CODE_W-1:0] code,
                            input logic [VALUE_W-1:0] val, input logic last,
                            input int n_typed, input screen_result_t r0, input screen_result_t r1);
    in_valid    <= 1'b1;
    valid_up     = 1'b1;
    event_type  <= ty;
    event_code  <= code;
    event_value <= val;
    batch_end   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_event(ty, code, val, last, n_typed == FROM_PREDICTOR);
    if (n_typed > 0) awaited_results.push_back(r0);
    if (n_typed > 1) awaited_results.push_back(r1);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      valid_up  = 1'b0;
      repeat (pick_len()) @(posedge clk);
    end
  endtask

  // Stops offering and waits for every awaited result.
  task automatic settle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up  = 1'b0;
    end
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_screen_size(input logic [SCR_W-1:0] w, input logic [SCR_W-1:0] h);
    settle();
    // events with no result may still be in the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_enable <= 1'b1;
    write_index  <= REG_SCREEN_WIDTH;
    write_data   <= w;
    @(posedge clk);
    screen_w = w;
    write_index <= REG_SCREEN_HEIGHT;
    write_data  <= h;
    @(posedge clk);
    screen_h = h;
    write_enable <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] axis_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'(POS_MAX);
      2:       return $urandom | 32'h0000_8000;
      3:       return $urandom;
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  // Mostly well-formed batches: axis moves, button changes, a closing event; some noise.
  task automatic send_batch(inout int sent);
    int                 n;
    int                 pick;
    logic [TYPE_W-1:0]  ty;
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] val;
    logic               last;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      ty   = TYPE_W'($urandom);
      code = CODE_W'($urandom);
      val  = $urandom;
      if (pick < 45) begin
        ty   = EVT_ABS;
        code = $urandom_range(0, 1) ? CODE_Y : CODE_X;
        val  = axis_value();
      end else if (pick < 65) begin
        ty   = EVT_KEY;
        code = $urandom_range(0, 1) ? CODE_RIGHT : CODE_LEFT;
        if ($urandom_range(0, 1)) val = '0;
      end else if (pick < 75) begin
        ty = EVT_ABS;
      end else if (pick < 85) begin
        ty = EVT_KEY;
      end
      last = (i == n - 1) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 19) == 0);
      send_event(ty, code, val, last, FROM_PREDICTOR, NO_RESULT, NO_RESULT);
    end
    sent += n;
  endtask

  function automatic event_row_t ev(input logic [TYPE_W-1:0] ty, input logic [CODE_W-1:0] code,
                                    input logic [VALUE_W-1:0] val, input logic last,
                                    input int n_typed,
                                    input screen_result_t r0 = NO_RESULT,
                                    input screen_result_t r1 = NO_RESULT);
    event_row_t row;
    row         = '0;
    row.ty      = ty;
    row.code    = code;
    row.val     = val;
    row.last    = last;
    row.n_typed = n_typed;
    row.r0      = r0;
    row.r1      = r1;
    return row;
  endfunction

  function automatic event_row_t cfg_row(input logic [SCR_W-1:0] w, input logic [SCR_W-1:0] h);
    event_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.w      = w;
    row.h      = h;
    return row;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    screen_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t ns: result with none awaited, expected nothing, got kind %0d x %0d y %0d",
                   $time, result_kind, screen_x, screen_y);
      end else begin
        want = awaited_results.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(result_kind));
        check_field("screen_x", 32'(want.x), 32'(screen_x));
        check_field("screen_y", 32'(want.y), 32'(screen_y));
        check_field("button_index", 32'(want.idx), 32'(button_index));
        check_field("button_pressed", 32'(want.pressed), 32'(button_pressed));
        check_field("last_result", 32'(want.last), 32'(last_result));
      end
    end
  end

  // receiver: random stall spans, plus one long hold-off on request
  initial begin : receiver
    int span;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_order) begin
        hold_order = 1'b0;
        out_stall <= 1'b1;
        span = HOLD_CYCLES;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        span = pick_len();
      end
      repeat (span) @(posedge clk);
    end
  end

  initial begin : stimulus
    int               sent;
    bit               hold_done;
    bit               pause_done;
    logic [SCR_W-1:0] w;
    logic [SCR_W-1:0] h;

    // reset size 1024 x 768, pointer at centre
    directed_rows.push_back(ev(EVT_KEY, CODE_LEFT, 32'd1, 1'b0, 1,
      '{KIND_BUTTON, 13'd511, 13'd383, IDX_LEFT, 1'b1, 1'b1}));
    directed_rows.push_back(ev(EVT_KEY, CODE_RIGHT, 32'd0, 1'b1, 1,
      '{KIND_BUTTON, 13'd511, 13'd383, IDX_RIGHT, 1'b0, 1'b1}));
    directed_rows.push_back(ev(EVT_ABS, CODE_X, 32'hFFFF_FFFF, 1'b0, 0));
    directed_rows.push_back(ev(EVT_ABS, CODE_Y, 32'd0, 1'b1, 1,
      '{KIND_MOTION, 13'd1024, 13'd0, 1'b0, 1'b0, 1'b1}));
    directed_rows.push_back(ev(EVT_ABS, CODE_Y, 32'h0000_8000, 1'b0, 0));
    directed_rows.push_back(ev(EVT_KEY, CODE_LEFT, 32'h8000_0000, 1'b1, 2,
      '{KIND_BUTTON, 13'd1024, 13'd768, IDX_LEFT, 1'b1, 1'b0},
      '{KIND_MOTION, 13'd1024, 13'd768, 1'b0, 1'b0, 1'b1}));
    directed_rows.push_back(ev(EVT_ABS, CODE_X, 32'd0, 1'b0, 0));
    directed_rows.push_back(ev(16'hFFFF, CODE_X, 32'h5A5A_5A5A, 1'b1, 1,
      '{KIND_MOTION, 13'd0, 13'd768, 1'b0, 1'b0, 1'b1}));
    directed_rows.push_back(ev(EVT_ABS, 16'h0002, 32'd100, 1'b1, 0));
    directed_rows.push_back(ev(EVT_KEY, 16'h0112, 32'd1, 1'b1, 0));
    directed_rows.push_back(ev(EVT_ABS, CODE_LEFT, 32'd7, 1'b0, 0));
    directed_rows.push_back(ev(EVT_KEY, CODE_X, 32'd1, 1'b1, 0));
    directed_rows.push_back(ev(EVT_ABS, CODE_X, 32'd32767, 1'b0, FROM_PREDICTOR));
    directed_rows.push_back(ev(EVT_ABS, CODE_Y, 32'd12345, 1'b0, FROM_PREDICTOR));
    directed_rows.push_back(ev(EVT_KEY, CODE_RIGHT, 32'd1, 1'b1, FROM_PREDICTOR));
    directed_rows.push_back(ev(16'h0000, 16'hFFFF, 32'd0, 1'b0, FROM_PREDICTOR));
    directed_rows.push_back(ev(EVT_ABS, CODE_X, 32'd1, 1'b1, FROM_PREDICTOR));
    directed_rows.push_back(ev(EVT_KEY, CODE_LEFT, 32'd0, 1'b0, FROM_PREDICTOR));
    // zero screen size scales everything to the origin
    directed_rows.push_back(cfg_row(13'd0, 13'd0));
    directed_rows.push_back(ev(EVT_ABS, CODE_Y, 32'd500, 1'b0, FROM_PREDICTOR));
    directed_rows.push_back(ev(EVT_KEY, CODE_RIGHT, 32'd1, 1'b1, 2,
      '{KIND_BUTTON, 13'd0, 13'd0, IDX_RIGHT, 1'b1, 1'b0},
      '{KIND_MOTION, 13'd0, 13'd0, 1'b0, 1'b0, 1'b1}));
    directed_rows.push_back(cfg_row(13'd8191, 13'd8191));
    directed_rows.push_back(ev(EVT_KEY, CODE_LEFT, 32'd0, 1'b1, FROM_PREDICTOR));
    directed_rows.push_back(ev(EVT_ABS, CODE_X, 32'd32767, 1'b0, 0));
    directed_rows.push_back(ev(EVT_ABS, CODE_Y, 32'h0001_0000, 1'b1, 1,
      '{KIND_MOTION, 13'd8191, 13'd8191, 1'b0, 1'b0, 1'b1}));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        set_screen_size(directed_rows[i].w, directed_rows[i].h);
      else
        send_event(directed_rows[i].ty, directed_rows[i].code, directed_rows[i].val,
                   directed_rows[i].last, directed_rows[i].n_typed,
                   directed_rows[i].r0, directed_rows[i].r1);
    end

    for (int p = 0; p < PHASES; p++) begin
      w = (phase_w[p] < 0) ? SCR_W'($urandom_range(1, 8191)) : SCR_W'(phase_w[p]);
      h = (phase_h[p] < 0) ? SCR_W'($urandom_range(1, 8191)) : SCR_W'(phase_h[p]);
      set_screen_size(w, h);
      stall_pct  = phase_stall[p];
      gap_pct    = phase_gap[p];
      sent       = 0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      while (sent < ITEMS_PER_PHASE) begin
        if (p == PRESSURE_PHASE && !hold_done && sent >= 100) begin
          hold_order = 1'b1;
          hold_done  = 1'b1;
        end
        if (p == PRESSURE_PHASE && !pause_done && sent >= 200) begin
          settle();
          pause_done = 1'b1;
        end
        send_batch(sent);
      end
    end

    settle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
